### src/ikpd_pkg.sv
// shared types, constants and widths for the ignition key position decoder
// no dependencies; imported by every module under src
package ikpd_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COEF_W    = 16;
  localparam int Y_W       = FRAC_BITS + 4;
  localparam int PROD_W    = COEF_W + Y_W;
  localparam int ACC_W     = FRAC_BITS + 21;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // filter output limits, rounding constant and hysteresis thresholds
  localparam logic signed [ACC_W-1:0] Y_HI =
    ACC_W'((64'sd1 <<< (Y_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_LO = ACC_W'(-(64'sd1 <<< (Y_W - 1)));
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [Y_W-1:0] LVL_QUARTER = Y_W'(64'sd1 <<< (FRAC_BITS - 2));
  localparam logic signed [Y_W-1:0] LVL_3QUARTER =
    Y_W'(64'sd3 * (64'sd1 <<< (FRAC_BITS - 2)));
  localparam logic signed [Y_W-1:0] LVL_ONE = Y_W'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [1:0] {
    LVL_OFF,
    LVL_ON,
    LVL_INVALID
  } level_t;

  typedef enum logic [1:0] {
    KEY_OFF,
    KEY_ACC,
    KEY_CRANK
  } key_t;

  typedef enum logic [1:0] {
    REG_ENABLE,
    REG_COEF_A0,
    REG_COEF_A1,
    REG_COEF_B1
  } reg_idx_t;

  typedef struct packed {
    logic                     enable;
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] b1;
  } cfg_t;

  // level of one lane: registered value and the value it takes on advance
  typedef struct packed {
    level_t cur;
    level_t nxt;
  } lane_stat_t;

endpackage

### src/ikpd_lane.sv
// one contact lane: first-order iir filter with rounding and saturation,
// then the hysteresis level decision; depends on ikpd_pkg
module ikpd_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               x,
  input  ikpd_pkg::cfg_t     cfg,
  input  logic               adv,
  output ikpd_pkg::lane_stat_t stat
);
  import ikpd_pkg::*;

  logic                    x_prev_r;
  logic signed [Y_W-1:0]   y_prev_r;
  logic signed [Y_W-1:0]   y_nxt;
  logic signed [PROD_W-1:0] fb_prod;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] scaled;
  logic signed [ACC_W-1:0] term_a0;
  logic signed [ACC_W-1:0] term_a1;
  level_t                  level_r;
  level_t                  level_nxt;

  assign fb_prod = cfg.b1 * y_prev_r;
  assign term_a0 = x ? (ACC_W'(cfg.a0) <<< FRAC_BITS) : '0;
  assign term_a1 = x_prev_r ? (ACC_W'(cfg.a1) <<< FRAC_BITS) : '0;
  assign sum     = term_a0 + term_a1 + ACC_W'(fb_prod) + RND_HALF;
  assign scaled  = sum >>> FRAC_BITS;

  always_comb begin
    if (scaled > Y_HI) begin
      y_nxt = Y_HI[Y_W-1:0];
    end else if (scaled < Y_LO) begin
      y_nxt = Y_LO[Y_W-1:0];
    end else begin
      y_nxt = scaled[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_prev_r <= 1'b0;
      y_prev_r <= '0;
    end else if (load) begin
      x_prev_r <= x;
      y_prev_r <= y_nxt;
    end
  end

  // level decides on the filter output held in y_prev_r
  always_comb begin
    priority if (y_prev_r > LVL_ONE || y_prev_r < 0) begin
      level_nxt = LVL_INVALID;
    end else if (y_prev_r > LVL_3QUARTER) begin
      level_nxt = LVL_ON;
    end else if (y_prev_r < LVL_QUARTER) begin
      level_nxt = LVL_OFF;
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_OFF;
    end else if (adv) begin
      level_r <= level_nxt;
    end
  end

  assign stat.cur = level_r;
  assign stat.nxt = level_nxt;

endmodule

### src/ikpd_merge.sv
// merging stage: key position state machine fed by both lane levels
// depends on ikpd_pkg
module ikpd_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 enable,
  input  ikpd_pkg::lane_stat_t acc_stat,
  input  ikpd_pkg::lane_stat_t start_stat,
  output ikpd_pkg::key_t       key
);
  import ikpd_pkg::*;

  key_t key_r;
  key_t key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_OFF;
    end else begin
      key_r <= key_nxt;
    end
  end

  always_comb begin
    key_nxt = key_r;
    if (adv && enable) begin
      priority if (start_stat.nxt == LVL_ON) begin
        key_nxt = KEY_CRANK;
      end else if (acc_stat.nxt == LVL_ON && start_stat.nxt == LVL_OFF &&
                   key_r != KEY_CRANK) begin
        key_nxt = KEY_ACC;
      end else if (acc_stat.nxt == LVL_OFF && start_stat.nxt == LVL_OFF) begin
        key_nxt = KEY_OFF;
      end else begin
        key_nxt = key_r;
      end
    end
  end

  assign key = key_r;

endmodule

### src/ignition_key_position_decoder_unit.sv
// top level of the ignition key position decoder: apb register file, two
// filter lanes, key position merge and output register; depends on ikpd_pkg,
// ikpd_lane and ikpd_merge
//
// channel   dir   handshake            payload
// in_       in    in_tvalid/tready     tdata[0] acc_raw, [1] start_raw
// out_      out   out_tvalid/tready    tdata[1:0] key, [3:2] acc lvl, [5:4] start lvl
// cfg_      in    apb psel/penable     enable, coef_a0, coef_a1, coef_b1 at 0x0..0xc
//
// one transaction per cycle sustained while out_tready is high; an accepted input
// is registered in the filter stage, then in the level and key stage that drives out_tvalid
// the filter stage is bounded by one 16 x 18 multiply plus a four-term add
// synchronous active-low reset clears filter history, levels, key and coefficients, and sets enable
// out_tready low holds the output register; in_tready drops only when both
// stages are full, so no transaction is lost or repeated
module ignition_key_position_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // bit 0 acc_raw, bit 1 start_raw, bits 7:2 zero
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // bits 1:0 key_position, 3:2 acc_level, 5:4 start_level, 7:6 zero
  output logic [7:0]                    out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ikpd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ikpd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ikpd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import ikpd_pkg::*;

  cfg_t       cfg_r;
  reg_idx_t   cfg_idx;
  logic       cfg_wr;
  logic       in_acc;
  logic       s1_valid_r;
  logic       s1_move;
  logic       out_valid_r;
  logic       out_free;
  lane_stat_t acc_stat;
  lane_stat_t start_stat;
  key_t       key;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b1;
      cfg_r.a0     <= '0;
      cfg_r.a1     <= '0;
      cfg_r.b1     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:  cfg_r.enable <= cfg_pwdata[0];
        REG_COEF_A0: cfg_r.a0     <= cfg_pwdata[COEF_W-1:0];
        REG_COEF_A1: cfg_r.a1     <= cfg_pwdata[COEF_W-1:0];
        REG_COEF_B1: cfg_r.b1     <= cfg_pwdata[COEF_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:  cfg_prdata = CFG_DW'(cfg_r.enable);
      REG_COEF_A0: cfg_prdata = CFG_DW'(cfg_r.a0);
      REG_COEF_A1: cfg_prdata = CFG_DW'(cfg_r.a1);
      REG_COEF_B1: cfg_prdata = CFG_DW'(cfg_r.b1);
    endcase
  end

  // ---------------- pipeline control ----------------
  // stage 1 holds the new filter outputs inside the lanes; the output
  // register is the level and key state itself, marked by out_valid_r
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // ---------------- lanes ----------------
  ikpd_lane u_lane_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .x     (in_tdata[0]),
    .cfg   (cfg_r),
    .adv   (s1_move),
    .stat  (acc_stat)
  );

  ikpd_lane u_lane_start (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc),
    .x     (in_tdata[1]),
    .cfg   (cfg_r),
    .adv   (s1_move),
    .stat  (start_stat)
  );

  // ---------------- merge ----------------
  ikpd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (s1_move),
    .enable     (cfg_r.enable),
    .acc_stat   (acc_stat),
    .start_stat (start_stat),
    .key        (key)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, start_stat.cur, acc_stat.cur, key};

  // ---------------- assertions ----------------
  // key position frozen while updates are disabled
  a_hold_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && !cfg_r.enable) |=> $stable(key))
    else $error("key position changed while disabled");

  // an enabled update with start on must land in the start position
  a_start_wins: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && cfg_r.enable) |=> (start_stat.cur != LVL_ON || key == KEY_CRANK))
    else $error("start level on but key position not start");

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // a stage 1 transaction moving on must appear at the output
  a_move_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("transaction lost between stages");

endmodule

### bench/tb_top.sv
// self-checking bench for the ignition key position decoder: drives raw contact ticks and
// apb coefficient and enable writes, predicts key position and both levels, compares every result
// depends on ikpd_pkg and ignition_key_position_decoder_unit from src
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ikpd_pkg::*;

  // latency of the block plus margin, used before config writes and at the end
  localparam int LAT_CYCLES  = 4;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES  = 12;
  localparam int NUM_PRESETS = 9;
  localparam int NUM_ROWS    = 37;
  localparam int REPORT_MAX  = 10;

  // one result, packed as on out_tdata: key lowest, then acc level, then start level
  typedef struct packed {
    level_t start_lvl;
    level_t acc_lvl;
    key_t   key;
  } key_report_t;

  // directed table: a register write, a tick with a typed result, or a predicted tick
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_KNOWN,
    ROW_PREDICT
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] wdata;
    logic        acc_raw;
    logic        start_raw;
    key_t        key;
    level_t      acc_lvl;
    level_t      start_lvl;
  } dir_row_t;

  typedef struct packed {
    logic        en;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] b1;
  } coef_set_t;

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // zero coefficients after reset: every filter output rounds to zero
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_OFF,   LVL_OFF,     LVL_OFF},
    // unity gain on the current sample: levels follow the contacts
    '{ROW_WRITE,   REG_COEF_A0, 32'h0000_4000, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b0, KEY_ACC,   LVL_ON,      LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_CRANK, LVL_ON,      LVL_ON},
    // start holds until both levels are off
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b0, KEY_CRANK, LVL_ON,      LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b1, KEY_CRANK, LVL_OFF,     LVL_ON},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    // enable written with upper bits set, bit 0 clear: key position frozen
    '{ROW_WRITE,   REG_ENABLE,  32'hFFFF_FFFE, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b0, KEY_OFF,   LVL_ON,      LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b1, KEY_OFF,   LVL_OFF,     LVL_ON},
    '{ROW_WRITE,   REG_ENABLE,  32'h0000_0001, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b1, KEY_CRANK, LVL_OFF,     LVL_ON},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_CRANK, LVL_ON,      LVL_ON},
    // gain -1.0 with junk above bit 15: negative outputs are invalid, key holds
    '{ROW_WRITE,   REG_COEF_A0, 32'hABCD_C000, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_CRANK, LVL_INVALID, LVL_INVALID},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    // largest positive gain: output above 1.0 is invalid
    '{ROW_WRITE,   REG_COEF_A0, 32'h0000_7FFF, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b1, 1'b0, KEY_OFF,   LVL_INVALID, LVL_OFF},
    // most negative gain on the start lane
    '{ROW_WRITE,   REG_COEF_A0, 32'h0000_8000, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_KNOWN,   REG_ENABLE,  32'h0,         1'b0, 1'b1, KEY_OFF,   LVL_OFF,     LVL_INVALID},
    // two-tap average lands at 0.5, inside the hysteresis band
    '{ROW_WRITE,   REG_COEF_A0, 32'h0000_2000, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_WRITE,   REG_COEF_A1, 32'h0000_2000, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b1, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b1, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b0, 1'b1, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b0, 1'b1, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    // all gains at the positive extreme: feedback drives the output into saturation
    '{ROW_WRITE,   REG_COEF_A0, 32'h0000_7FFF, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_WRITE,   REG_COEF_A1, 32'h0000_7FFF, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_WRITE,   REG_COEF_B1, 32'h0000_7FFF, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_OFF,   LVL_OFF,     LVL_OFF},
    // feedback at -2.0 flips a saturated output to the negative limit
    '{ROW_WRITE,   REG_COEF_B1, 32'h0000_8000, 1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b1, 1'b1, KEY_OFF,   LVL_OFF,     LVL_OFF},
    '{ROW_PREDICT, REG_ENABLE,  32'h0,         1'b0, 1'b0, KEY_OFF,   LVL_OFF,     LVL_OFF}
  };

  // coefficient settings for the random phases; later phases draw random ones
  localparam coef_set_t PRESETS [NUM_PRESETS] = '{
    '{1'b1, 16'h4000, 16'h0000, 16'h0000},  // direct follow
    '{1'b1, 16'h1000, 16'h1000, 16'h2000},  // low-pass, unity dc gain
    '{1'b1, 16'h0800, 16'h0800, 16'h3000},  // slower low-pass
    '{1'b1, 16'h2000, 16'h2000, 16'h0000},  // two-tap average
    '{1'b0, 16'h1000, 16'h1000, 16'h2000},  // filters run, key frozen
    '{1'b1, 16'h7FFF, 16'h8000, 16'h7FFF},  // extremes
    '{1'b1, 16'h8000, 16'h7FFF, 16'h8000},  // opposite extremes
    '{1'b1, 16'h3000, 16'h0000, 16'h4000},  // integrator, runs into saturation
    '{1'b1, 16'h5000, 16'h0000, 16'hE000}   // overshoot with negative feedback
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic [7:0]          in_tdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // predictor state: lane 0 is accessory, lane 1 is start
  bit          raw_prev [2];
  longint      filt_prev [2];
  level_t      lane_level [2];
  key_t        key_held;
  bit          key_enable;
  longint      gain_a0, gain_a1, gain_b1;

  key_report_t pending_reports [$];
  int          mismatch_count  = 0;
  int          ticks_sent      = 0;
  int          reports_checked = 0;
  int          writes_done     = 0;
  int          burst_left      = 1;

  // receiver stall pattern, re-drawn each time ready_slot wraps
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_slot    = 0;

  always #5 clk = ~clk;

  ignition_key_position_decoder_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // one filter tick: exact sum at double fraction bits, round half up, saturate
  function automatic longint filter_tick(int lane, bit x);
    longint sum;
    longint y;
    sum = 0;
    if (x) sum += gain_a0 <<< FRAC_BITS;
    if (raw_prev[lane]) sum += gain_a1 <<< FRAC_BITS;
    sum += gain_b1 * filt_prev[lane];
    sum += longint'(1) <<< (FRAC_BITS - 1);
    y = sum >>> FRAC_BITS;  // arithmetic shift is the floor
    if (y > (longint'(1) <<< (Y_W - 1)) - 1) y = (longint'(1) <<< (Y_W - 1)) - 1;
    if (y < -(longint'(1) <<< (Y_W - 1))) y = -(longint'(1) <<< (Y_W - 1));
    raw_prev[lane]  = x;
    filt_prev[lane] = y;
    return y;
  endfunction

  // hysteresis: later tests override earlier ones, in between the level holds
  function automatic level_t settle_level(longint y, level_t held);
    level_t lvl;
    lvl = held;
    if (y < (longint'(1) <<< (FRAC_BITS - 2))) lvl = LVL_OFF;
    if (y > 3 * (longint'(1) <<< (FRAC_BITS - 2))) lvl = LVL_ON;
    if (y > (longint'(1) <<< FRAC_BITS) || y < 0) lvl = LVL_INVALID;
    return lvl;
  endfunction

  // advance the predictor by one tick and return the key report it gives
  function automatic key_report_t decode_tick(bit acc_raw, bit start_raw);
    key_report_t rep;
    lane_level[0] = settle_level(filter_tick(0, acc_raw), lane_level[0]);
    lane_level[1] = settle_level(filter_tick(1, start_raw), lane_level[1]);
    if (key_enable) begin
      if (lane_level[0] == LVL_OFF && lane_level[1] == LVL_OFF) key_held = KEY_OFF;
      if (lane_level[0] == LVL_ON && lane_level[1] == LVL_OFF && key_held != KEY_CRANK)
        key_held = KEY_ACC;
      if (lane_level[1] == LVL_ON) key_held = KEY_CRANK;
    end
    rep.key       = key_held;
    rep.acc_lvl   = lane_level[0];
    rep.start_lvl = lane_level[1];
    return rep;
  endfunction

  // drive one tick and wait for its handshake; typed result replaces the prediction
  task automatic push_tick(bit acc_raw, bit start_raw, bit known, key_report_t typed);
    key_report_t rep;
    in_tdata  <= {6'b0, start_raw, acc_raw};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    rep = decode_tick(acc_raw, start_raw);
    pending_reports.push_back(known ? typed : rep);
    ticks_sent++;
  endtask

  // burst pacing: after a burst, drop valid for a random gap (sometimes none)
  task automatic pace_sender();
    int idle_gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
      idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle_gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle_gap) @(posedge clk);
      end
    end
  endtask

  // let the pipeline drain, then an apb write with setup and access phases
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx) << 2;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_ENABLE:  key_enable = data[0];
      REG_COEF_A0: gain_a0 = longint'($signed(data[15:0]));
      REG_COEF_A1: gain_a1 = longint'($signed(data[15:0]));
      REG_COEF_B1: gain_b1 = longint'($signed(data[15:0]));
      default: ;
    endcase
    writes_done++;
  endtask

  // random ticks shaped like key turns: positions held for runs, some noise
  task automatic run_key_turns(int n_ticks);
    int  pos;
    int  hold_run;
    bit  noisy_run;
    bit  start_only;
    bit  a, s;
    key_report_t none;
    hold_run   = 0;
    pos        = 0;
    noisy_run  = 1'b0;
    start_only = 1'b0;
    none       = '0;
    for (int i = 0; i < n_ticks; i++) begin
      if (hold_run == 0) begin
        pos        = $urandom_range(0, 2);
        hold_run   = $urandom_range(1, 24);
        noisy_run  = ($urandom_range(0, 6) == 0);
        start_only = ($urandom_range(0, 2) == 0);
      end
      case (pos)
        0:       begin a = 1'b0; s = 1'b0; end
        1:       begin a = 1'b1; s = 1'b0; end
        default: begin a = !start_only; s = 1'b1; end
      endcase
      if (noisy_run) begin
        a = 1'($urandom_range(0, 1));
        s = 1'($urandom_range(0, 1));
      end else if ($urandom_range(0, 9) == 0) begin
        // contact bounce on one of the two bits
        if ($urandom_range(0, 1)) a = !a;
        else s = !s;
      end
      push_tick(a, s, 1'b0, none);
      pace_sender();
      hold_run--;
    end
  endtask

  // receiver: free-running stall pattern, always with at least one ready slot in the 16-bit pattern
  always @(posedge clk) begin
    if (ready_slot == 63) begin
      ready_slot <= 0;
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'h8001;
        default: ready_pattern <= 16'($urandom) | 16'h0001;
      endcase
    end else begin
      ready_slot <= ready_slot + 1;
    end
    out_tready <= ready_pattern[ready_slot[3:0]];
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    key_report_t got;
    key_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = key_report_t'(out_tdata[5:0]);
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result 0x%02h arrived with no transaction pending", $realtime,
                   out_tdata);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got.key !== want.key || got.acc_lvl !== want.acc_lvl ||
            got.start_lvl !== want.start_lvl) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: key exp %0d got %0d, acc lvl exp %0d got %0d, start lvl exp %0d got %0d",
                     $realtime, want.key, got.key, want.acc_lvl, got.acc_lvl,
                     want.start_lvl, got.start_lvl);
        end
      end
    end
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    key_report_t typed;
    coef_set_t   cs;
    in_tdata    <= '0;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    // predictor reset state
    raw_prev   = '{1'b0, 1'b0};
    filt_prev  = '{0, 0};
    lane_level = '{LVL_OFF, LVL_OFF};
    key_held   = KEY_OFF;
    key_enable = 1'b1;
    gain_a0    = 0;
    gain_a1    = 0;
    gain_b1    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_WRITE) begin
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].wdata);
      end else begin
        typed.key       = DIR_ROWS[r].key;
        typed.acc_lvl   = DIR_ROWS[r].acc_lvl;
        typed.start_lvl = DIR_ROWS[r].start_lvl;
        push_tick(DIR_ROWS[r].acc_raw, DIR_ROWS[r].start_raw,
                  DIR_ROWS[r].kind == ROW_KNOWN, typed);
        pace_sender();
      end
    end

    // random phases: presets first, then random coefficients and enable
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < NUM_PRESETS) begin
        cs = PRESETS[ph];
      end else begin
        cs.en = ($urandom_range(0, 4) != 0);
        cs.a0 = 16'($urandom);
        cs.a1 = 16'($urandom);
        cs.b1 = 16'($urandom);
      end
      write_reg(REG_ENABLE,  {31'($urandom), cs.en});
      write_reg(REG_COEF_A0, {16'($urandom), cs.a0});
      write_reg(REG_COEF_A1, {16'($urandom), cs.a1});
      write_reg(REG_COEF_B1, {16'($urandom), cs.b1});
      run_key_turns(PHASE_ITEMS);
    end

    // drain and let any stray result show up
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES * 4) @(posedge clk);

    $display("ran %0d contact ticks and %0d register writes over %0d filter settings",
             ticks_sent, writes_done, NUM_PHASES + 1);
    $display("checked %0d key reports, key frozen and running, with saturated and invalid levels",
             reports_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
src/ikpd_pkg.sv
src/ikpd_lane.sv
src/ikpd_merge.sv
src/ignition_key_position_decoder_unit.sv
bench/tb_top.sv
